// ===== sv/ekfp_pkg.sv =====
// Shared types, constants and the MAC address role table of the EAPOL-Key frame parser.
package ekfp_pkg;

   // Width used for position and length arithmetic (16-bit lengths plus carry room).
   localparam int CMP_W = 18;

   localparam int MIN_FRAME_BYTES  = 36;
   localparam int RADIOTAP_MIN     = 4;
   localparam int MAC_HDR_BASE     = 24;
   localparam int MAC_HDR_ADDR4    = 6;
   localparam int MAC_HDR_QOS      = 2;
   localparam int LLC_SNAP_BYTES   = 8;
   localparam int EAPOL_HDR_BYTES  = 4;
   localparam int PAYLOAD_MIC_MIN  = 97;
   localparam int KEY_BODY_MIN     = 96;

   localparam logic [15:0] FC_DS_MASK      = 16'h0300;
   localparam logic [7:0]  LLC_SAP         = 8'hAA;
   localparam logic [7:0]  LLC_CTRL_UI     = 8'h03;
   localparam logic [15:0] ETHERTYPE_EAPOL = 16'h888E;
   localparam logic [7:0]  EAPOL_TYPE_KEY  = 8'h03;

   // Key body byte offsets (relative to the first descriptor byte)
   localparam int K_KEY_LEN_LO  = 4;
   localparam int K_REPLAY_LAST = 12;
   localparam int K_NONCE_LAST  = 44;
   localparam int K_IV_LAST     = 60;
   localparam int K_RSC_LAST    = 68;
   localparam int K_ID_FIRST    = 69;
   localparam int K_ID_LAST     = 76;
   localparam int K_MIC_FIRST   = 77;
   localparam int K_MIC_LAST    = 92;
   localparam int K_KDL_HI      = 93;
   localparam int K_KDL_LO      = 94;
   localparam int K_KEYDATA     = 95;
   localparam int K_REPLAY      = 5;
   localparam int K_NONCE       = 13;
   localparam int K_IV          = 45;
   localparam int K_RSC         = 61;

   typedef enum logic [3:0] {
      TAG_OTHER     = 4'd0,
      TAG_DST       = 4'd1,
      TAG_SRC       = 4'd2,
      TAG_BSSID     = 4'd3,
      TAG_EAPOL_HDR = 4'd4,
      TAG_KEY_FIXED = 4'd5,
      TAG_REPLAY    = 4'd6,
      TAG_NONCE     = 4'd7,
      TAG_IV        = 4'd8,
      TAG_RSC       = 4'd9,
      TAG_MIC       = 4'd10,
      TAG_KEYDATA   = 4'd11
   } tag_type;

   typedef enum logic [3:0] {
      ST_OK           = 4'd0,
      ST_SHORT        = 4'd1,
      ST_RADIOTAP     = 4'd2,
      ST_NO_LLC_ROOM  = 4'd3,
      ST_FOUR_ADDR    = 4'd4,
      ST_LLC_BAD      = 4'd5,
      ST_ETHERTYPE    = 4'd6,
      ST_EAPOL_TRUNC  = 4'd7,
      ST_NOT_KEY      = 4'd8,
      ST_PAYLOAD_OVER = 4'd9,
      ST_KEY_TRUNC    = 4'd10,
      ST_KEYDATA_OVER = 4'd11,
      ST_OVERSIZE     = 4'd12
   } status_type;

   // Per-frame parse state; err holds the first content error (ST_OK for none)
   typedef struct packed {
      logic [15:0] rt_len;
      logic [15:0] fc;
      logic [5:0]  mac_hdr_len;
      logic [15:0] eapol_len;
      logic [7:0]  ethertype_hi;
      status_type  err;
      logic [7:0]  desc_type;
      logic [15:0] key_flags;
      logic [15:0] key_len;
      logic [15:0] key_data_len;
   } parse_state_type;

   typedef struct packed {
      logic [7:0]  byte_out;
      logic        in_payload;
      tag_type     field_tag;
      logic [11:0] field_offset;
      logic        frame_end;
      status_type  status;
      logic [7:0]  key_desc_type;
      logic [15:0] key_flags;
      logic [15:0] key_size;
      logic [15:0] key_data_size;
      logic        has_mic;
      logic        from_ap;
   } result_type;

   // Address role by {from-DS, to-DS} and address slot (addr1..addr3)
   function automatic tag_type mac_role(input logic [1:0] ds, input logic [1:0] slot);
      tag_type r;
      r = TAG_OTHER;
      unique case (ds)
         2'd0: r = (slot == 2'd0) ? TAG_DST : (slot == 2'd1) ? TAG_SRC :
                   (slot == 2'd2) ? TAG_BSSID : TAG_OTHER;
         2'd1: r = (slot == 2'd0) ? TAG_BSSID : (slot == 2'd1) ? TAG_SRC :
                   (slot == 2'd2) ? TAG_DST : TAG_OTHER;
         2'd2: r = (slot == 2'd0) ? TAG_DST : (slot == 2'd1) ? TAG_BSSID :
                   (slot == 2'd2) ? TAG_SRC : TAG_OTHER;
         default: r = TAG_OTHER;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] mac_hdr_len(input logic [15:0] fc);
      logic [5:0] len;
      len = 6'(MAC_HDR_BASE);
      if ((fc & FC_DS_MASK) == FC_DS_MASK) len = len + 6'(MAC_HDR_ADDR4);
      if (fc[7]) len = len + 6'(MAC_HDR_QOS);
      return len;
   endfunction

endpackage

// ===== sv/ekfp_step.sv =====
// Per-byte parse logic: field tagging, MIC zeroing, state update and end-of-frame status.
module ekfp_step
   import ekfp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 4096
) (
   input  logic [7:0]                              byte_in,
   input  logic                                    last_byte,
   input  logic [$clog2(MAX_FRAME_BYTES + 1)-1:0]  pos,
   input  parse_state_type                         st,
   output parse_state_type                         st_n,
   output logic [$clog2(MAX_FRAME_BYTES + 1)-1:0]  pos_n,
   output result_type                              res
);

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

   logic             over;
   logic             active;
   logic [CMP_W-1:0] p_x;
   logic [CMP_W-1:0] rt_x;
   logic [CMP_W-1:0] h_x;
   logic [CMP_W-1:0] i_x;
   logic [CMP_W-1:0] k_x;
   logic [4:0]       hs;
   logic [1:0]       slot;
   logic [2:0]       addr_off;

   logic [7:0]       pb_byte;
   logic             pb_inpl;
   tag_type          pb_tag;
   logic [11:0]      pb_off;

   status_type       sum_status;
   logic             sum_valid;

   assign over   = pos >= POS_W'(MAX_FRAME_BYTES);
   assign p_x    = CMP_W'(pos);
   assign rt_x   = CMP_W'(st.rt_len);
   assign active = (p_x >= CMP_W'(4)) && (rt_x >= CMP_W'(RADIOTAP_MIN)) && (p_x >= rt_x);
   assign h_x    = p_x - rt_x;
   assign i_x    = h_x - CMP_W'(st.mac_hdr_len);
   assign k_x    = i_x - CMP_W'(LLC_SNAP_BYTES + EAPOL_HDR_BYTES);

   // Address slot within the three 6-byte address fields
   assign hs = h_x[4:0] - 5'd4;
   always_comb begin
      if (hs < 5'd6) begin
         slot     = 2'd0;
         addr_off = hs[2:0];
      end else if (hs < 5'd12) begin
         slot     = 2'd1;
         addr_off = 3'(hs - 5'd6);
      end else begin
         slot     = 2'd2;
         addr_off = 3'(hs - 5'd12);
      end
   end

   assign pos_n = last_byte ? '0 : (over ? POS_W'(MAX_FRAME_BYTES) : pos + POS_W'(1));

   // Byte tagging and state update
   always_comb begin
      st_n    = st;
      pb_byte = byte_in;
      pb_inpl = 1'b0;
      pb_tag  = TAG_OTHER;
      pb_off  = '0;
      if (!over) begin
         if (pos == POS_W'(2)) st_n.rt_len = {8'h00, byte_in};
         if (pos == POS_W'(3)) st_n.rt_len[15:8] = byte_in;
         if (active) begin
            if (h_x == CMP_W'(0)) begin
               st_n.fc = {8'h00, byte_in};
            end else if (h_x == CMP_W'(1)) begin
               st_n.fc[15:8]    = byte_in;
               st_n.mac_hdr_len = mac_hdr_len({byte_in, st.fc[7:0]});
               if ((byte_in[1:0] == 2'b11) && (st.err == ST_OK)) st_n.err = ST_FOUR_ADDR;
            end else if (st.err == ST_OK) begin
               if ((h_x >= CMP_W'(4)) && (h_x < CMP_W'(22))) begin
                  pb_tag = mac_role(st.fc[9:8], slot);
                  pb_off = 12'(addr_off);
               end else if (h_x >= CMP_W'(st.mac_hdr_len)) begin
                  if (i_x < CMP_W'(LLC_SNAP_BYTES)) begin
                     // LLC/SNAP header and ethertype
                     if ((i_x == CMP_W'(0) || i_x == CMP_W'(1)) && byte_in != LLC_SAP)
                        st_n.err = ST_LLC_BAD;
                     if (i_x == CMP_W'(2) && byte_in != LLC_CTRL_UI) st_n.err = ST_LLC_BAD;
                     if (i_x == CMP_W'(6)) st_n.ethertype_hi = byte_in;
                     if (i_x == CMP_W'(7) && {st.ethertype_hi, byte_in} != ETHERTYPE_EAPOL)
                        st_n.err = ST_ETHERTYPE;
                  end else if (i_x < CMP_W'(LLC_SNAP_BYTES + EAPOL_HDR_BYTES)) begin
                     // EAPOL header: version, type, body length
                     pb_inpl = 1'b1;
                     pb_tag  = TAG_EAPOL_HDR;
                     pb_off  = 12'(i_x[1:0]);
                     if (i_x[1:0] == 2'd1 && byte_in != EAPOL_TYPE_KEY) st_n.err = ST_NOT_KEY;
                     if (i_x[1:0] == 2'd2) st_n.eapol_len = {byte_in, 8'h00};
                     if (i_x[1:0] == 2'd3) st_n.eapol_len[7:0] = byte_in;
                  end else begin
                     pb_inpl = k_x < CMP_W'(st.eapol_len);
                     if (k_x == CMP_W'(0))           st_n.desc_type         = byte_in;
                     else if (k_x == CMP_W'(1))      st_n.key_flags[15:8]   = byte_in;
                     else if (k_x == CMP_W'(2))      st_n.key_flags[7:0]    = byte_in;
                     else if (k_x == CMP_W'(3))      st_n.key_len[15:8]     = byte_in;
                     else if (k_x == CMP_W'(K_KEY_LEN_LO)) st_n.key_len[7:0] = byte_in;
                     else if (k_x == CMP_W'(K_KDL_HI)) st_n.key_data_len[15:8] = byte_in;
                     else if (k_x == CMP_W'(K_KDL_LO)) st_n.key_data_len[7:0]  = byte_in;

                     priority if (k_x <= CMP_W'(K_KEY_LEN_LO) ||
                                  (k_x >= CMP_W'(K_ID_FIRST) && k_x <= CMP_W'(K_ID_LAST)) ||
                                  k_x == CMP_W'(K_KDL_HI) || k_x == CMP_W'(K_KDL_LO)) begin
                        pb_tag = TAG_KEY_FIXED;
                        pb_off = k_x[11:0];
                     end else if (k_x <= CMP_W'(K_REPLAY_LAST)) begin
                        pb_tag = TAG_REPLAY;
                        pb_off = k_x[11:0] - 12'(K_REPLAY);
                     end else if (k_x <= CMP_W'(K_NONCE_LAST)) begin
                        pb_tag = TAG_NONCE;
                        pb_off = k_x[11:0] - 12'(K_NONCE);
                     end else if (k_x <= CMP_W'(K_IV_LAST)) begin
                        pb_tag = TAG_IV;
                        pb_off = k_x[11:0] - 12'(K_IV);
                     end else if (k_x <= CMP_W'(K_RSC_LAST)) begin
                        pb_tag = TAG_RSC;
                        pb_off = k_x[11:0] - 12'(K_RSC);
                     end else if (k_x >= CMP_W'(K_MIC_FIRST) && k_x <= CMP_W'(K_MIC_LAST)) begin
                        pb_tag = TAG_MIC;
                        pb_off = k_x[11:0] - 12'(K_MIC_FIRST);
                        if (st.eapol_len >= 16'(PAYLOAD_MIC_MIN - EAPOL_HDR_BYTES))
                           pb_byte = 8'h00;
                     end else if (k_x >= CMP_W'(K_KEYDATA) &&
                                  (k_x - CMP_W'(K_KEYDATA)) < CMP_W'(st.key_data_len)) begin
                        pb_tag = TAG_KEYDATA;
                        pb_off = k_x[11:0] - 12'(K_KEYDATA);
                     end else begin
                        pb_tag = TAG_OTHER;
                     end
                  end
               end
            end
         end
      end
   end

   // End-of-frame status, evaluated on the updated state
   logic [CMP_W-1:0] len_x;
   logic [CMP_W-1:0] rtn_x;
   logic [CMP_W-1:0] avail_x;
   logic [CMP_W-1:0] llc_end_x;
   logic [CMP_W-1:0] eapol_end_x;

   assign len_x       = p_x + CMP_W'(1);
   assign rtn_x       = CMP_W'(st_n.rt_len);
   assign avail_x     = len_x - rtn_x;
   assign llc_end_x   = CMP_W'(st_n.mac_hdr_len) + CMP_W'(LLC_SNAP_BYTES);
   assign eapol_end_x = llc_end_x + CMP_W'(EAPOL_HDR_BYTES);

   always_comb begin
      sum_status = ST_OK;
      if (last_byte) begin
         priority if (over)                                  sum_status = ST_OVERSIZE;
         else if (len_x < CMP_W'(MIN_FRAME_BYTES))           sum_status = ST_SHORT;
         else if (rtn_x < CMP_W'(RADIOTAP_MIN) || rtn_x >= len_x) sum_status = ST_RADIOTAP;
         else if (avail_x < llc_end_x)                       sum_status = ST_NO_LLC_ROOM;
         else if (st_n.err == ST_FOUR_ADDR || st_n.err == ST_LLC_BAD ||
                  st_n.err == ST_ETHERTYPE)                  sum_status = st_n.err;
         else if (avail_x < eapol_end_x)                     sum_status = ST_EAPOL_TRUNC;
         else if (st_n.err == ST_NOT_KEY)                    sum_status = ST_NOT_KEY;
         else if (avail_x < eapol_end_x + CMP_W'(st_n.eapol_len)) sum_status = ST_PAYLOAD_OVER;
         else if (avail_x < eapol_end_x + CMP_W'(KEY_BODY_MIN))  sum_status = ST_KEY_TRUNC;
         else if (avail_x < eapol_end_x + CMP_W'(K_KEYDATA) + CMP_W'(st_n.key_data_len))
            sum_status = ST_KEYDATA_OVER;
         else                                                sum_status = ST_OK;
      end
   end

   assign sum_valid = last_byte && (sum_status == ST_OK || sum_status == ST_KEYDATA_OVER);

   always_comb begin
      res                 = '0;
      res.byte_out        = pb_byte;
      res.in_payload      = pb_inpl;
      res.field_tag       = pb_tag;
      res.field_offset    = pb_off;
      res.frame_end       = last_byte;
      res.status          = sum_status;
      if (sum_valid) begin
         res.key_desc_type = st_n.desc_type;
         res.key_flags     = st_n.key_flags;
         res.key_size      = st_n.key_len;
         res.key_data_size = st_n.key_data_len;
         res.has_mic       = st_n.key_flags[8];
         res.from_ap       = ~st_n.fc[8];
      end
   end

endmodule

// ===== sv/eapol_key_frame_parser.sv =====
// EAPOL-Key frame parser top level: stream ports, input register, frame state, result register.
//
// Parses a captured radiotap + 802.11 frame presented one byte per transaction on the
// req_ stream (req_tlast marks the final byte). Every byte comes back on the rsp_ stream
// tagged with the field it belongs to (addresses by role from the DS bits, EAPOL header,
// key descriptor fields, MIC, key data) and its offset in that field; MIC bytes are zeroed
// when the EAPOL payload is at least 97 bytes. The transaction carrying rsp_tlast also
// reports the frame status and, for a good frame or one whose key data runs over, the key
// descriptor type, key info, key length, key data length, has_mic and from_ap; otherwise
// those are zero. Bytes beyond MAX_FRAME_BYTES are echoed untagged and the frame ends with
// the oversize status. The parser sustains one byte per clock: each byte is captured in
// an input register, parsed by one level of logic against the per-frame state, and lands
// in a result register. A full result register that is not taken stalls the input side
// one-for-one. All frame state returns to reset after the last byte, so frames may
// follow each other with no gap.
module eapol_key_frame_parser
   import ekfp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] byte_out, [8] in_payload, [12:9] field_tag, [24:13] field_offset,
   // [28:25] status, [36:29] key_desc_type, [52:37] key_flags, [68:53] key_size,
   // [84:69] key_data_size, [85] has_mic, [86] from_ap, [87] zero
   output logic [87:0] rsp_tdata,
   output logic        rsp_tlast    // frame_end
);

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

   // input register
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;

   // frame state
   logic [POS_W-1:0] pos_ff, pos_in;
   parse_state_type  st_ff, st_in;

   // result register
   logic             out_valid_ff, out_valid_in;
   result_type       out_res_ff, out_res_in;

   logic             advance;

   // a byte moves on when the result register is empty or being drained this cycle
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   ekfp_step #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_step (
      .byte_in  (in_byte_ff),
      .last_byte(in_last_ff),
      .pos      (pos_ff),
      .st       (st_ff),
      .st_n     (st_in),
      .pos_n    (pos_in),
      .res      (out_res_in)
   );

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         st_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            pos_ff <= pos_in;
            // the last byte of a frame leaves clean state for the next one
            st_ff  <= in_last_ff ? '0 : st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_res_ff <= out_res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_res_ff.frame_end;
   assign rsp_tdata  = {1'b0,
                        out_res_ff.from_ap,
                        out_res_ff.has_mic,
                        out_res_ff.key_data_size,
                        out_res_ff.key_size,
                        out_res_ff.key_flags,
                        out_res_ff.key_desc_type,
                        out_res_ff.status,
                        out_res_ff.field_offset,
                        out_res_ff.field_tag,
                        out_res_ff.in_payload,
                        out_res_ff.byte_out};

   // input side only stalls behind a held result
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled without a held result");

   // a frame's last byte returns the position counter to zero
   a_pos_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (pos_ff == '0))
      else $error("position not cleared after frame end");

   a_pos_cap: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_FRAME_BYTES))
      else $error("position beyond frame limit");

   // key fields only accompany a good frame or key data overrun
   a_summary_gate: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !(out_res_ff.frame_end &&
         (out_res_ff.status == ST_OK || out_res_ff.status == ST_KEYDATA_OVER)))
      |-> (out_res_ff.key_flags == '0 && out_res_ff.key_data_size == '0 &&
           !out_res_ff.from_ap))
      else $error("key fields reported on a failed or unfinished frame");

endmodule

// ===== tb/sv/ekfp_stream_checker.sv =====
// Stream checker for the EAPOL-Key frame parser: predicts every response and compares it.
`timescale 1ns / 100ps

module ekfp_stream_checker
   import ekfp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // last_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] byte_out, [8] in_payload, [12:9] field_tag, [24:13] field_offset,
   // [28:25] status, [36:29] key_desc_type, [52:37] key_flags, [68:53] key_size,
   // [84:69] key_data_size, [85] has_mic, [86] from_ap, [87] zero
   input  logic [87:0] rsp_tdata,
   input  logic        rsp_tlast,   // frame_end
   output int          fault_count,
   output int          pending_count
);

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

   // Per-frame parse state of the predictor
   logic [POS_W-1:0] pos;
   logic [15:0] rt_len;
   logic [15:0] fc;
   logic [5:0]  hdr_len;
   logic [15:0] eapol_len;
   logic [15:0] ethertype;
   status_type  first_err;
   logic [7:0]  desc_type;
   logic [15:0] key_flags;
   logic [15:0] key_len;
   logic [15:0] key_data_len;

   result_type expected_bytes[$];
   int         faults;

   function automatic tag_type addr_role(input logic [1:0] ds, input int slot);
      tag_type r;
      case (ds)
         2'd0:    r = (slot == 0) ? TAG_DST   : (slot == 1) ? TAG_SRC   : TAG_BSSID;
         2'd1:    r = (slot == 0) ? TAG_BSSID : (slot == 1) ? TAG_SRC   : TAG_DST;
         2'd2:    r = (slot == 0) ? TAG_DST   : (slot == 1) ? TAG_BSSID : TAG_SRC;
         default: r = TAG_OTHER;
      endcase
      return r;
   endfunction

   function automatic string show(input result_type r);
      return $sformatf({"byte %02h pl %0b tag %0d off %0d end %0b st %0d dt %02h ",
                        "ki %04h kl %04h kdl %04h mic %0b ap %0b"},
                       r.byte_out, r.in_payload, r.field_tag, r.field_offset, r.frame_end,
                       r.status, r.key_desc_type, r.key_flags, r.key_size,
                       r.key_data_size, r.has_mic, r.from_ap);
   endfunction

   task automatic clear_frame();
      pos          = '0;
      rt_len       = '0;
      fc           = '0;
      hdr_len      = '0;
      eapol_len    = '0;
      ethertype    = '0;
      first_err    = ST_OK;
      desc_type    = '0;
      key_flags    = '0;
      key_len      = '0;
      key_data_len = '0;
   endtask

   // Works out the response to one request byte and advances the frame state.
   task automatic parse_byte(input logic [7:0] b, input logic last, output result_type r);
      int         p, h, i, q, k, len, llc_end, hdr_end;
      logic       over;
      status_type st;
      r = '0;
      r.byte_out  = b;
      r.frame_end = last;
      r.field_tag = TAG_OTHER;
      r.status    = ST_OK;
      st          = ST_OK;
      p           = int'(pos);
      over        = p >= MAX_FRAME_BYTES;

      if (!over) begin
         if (p == 2) rt_len = {8'h00, b};
         if (p == 3) rt_len[15:8] = b;
         if (p >= 4 && rt_len >= 16'd4 && p >= int'(rt_len)) begin
            h = p - int'(rt_len);
            if (h == 0) begin
               fc = {8'h00, b};
            end else if (h == 1) begin
               fc[15:8] = b;
               hdr_len = 6'd24 + ((fc[9:8] == 2'b11) ? 6'd6 : 6'd0) + (fc[7] ? 6'd2 : 6'd0);
               if (fc[9:8] == 2'b11 && first_err == ST_OK) first_err = ST_FOUR_ADDR;
            end else if (first_err == ST_OK) begin
               if (h >= 4 && h < 22) begin
                  // three address slots, role picked by to-DS / from-DS
                  r.field_tag    = addr_role(fc[9:8], (h - 4) / 6);
                  r.field_offset = 12'((h - 4) % 6);
               end else if (h >= int'(hdr_len)) begin
                  i = h - int'(hdr_len);
                  if (i < 8) begin
                     // LLC/SNAP: only DSAP, SSAP, control and ethertype are checked
                     if ((i == 0 || i == 1) && b != 8'hAA) first_err = ST_LLC_BAD;
                     if (i == 2 && b != 8'h03) first_err = ST_LLC_BAD;
                     if (i == 6) ethertype = {b, 8'h00};
                     if (i == 7) begin
                        ethertype[7:0] = b;
                        if (ethertype != 16'h888E) first_err = ST_ETHERTYPE;
                     end
                  end else begin
                     q = i - 8;
                     if (q < 4) begin
                        r.in_payload   = 1'b1;
                        r.field_tag    = TAG_EAPOL_HDR;
                        r.field_offset = 12'(q);
                        if (q == 1 && b != 8'h03) first_err = ST_NOT_KEY;
                        if (q == 2) eapol_len = {b, 8'h00};
                        if (q == 3) eapol_len[7:0] = b;
                     end else begin
                        k = q - 4;
                        r.in_payload = k < int'(eapol_len);
                        case (k)
                           0:  desc_type          = b;
                           1:  key_flags[15:8]    = b;
                           2:  key_flags[7:0]     = b;
                           3:  key_len[15:8]      = b;
                           4:  key_len[7:0]       = b;
                           93: key_data_len[15:8] = b;
                           94: key_data_len[7:0]  = b;
                           default: ;
                        endcase
                        if (k <= 4 || (k >= 69 && k <= 76) || k == 93 || k == 94) begin
                           r.field_tag = TAG_KEY_FIXED; r.field_offset = 12'(k);
                        end else if (k <= 12) begin
                           r.field_tag = TAG_REPLAY;    r.field_offset = 12'(k - 5);
                        end else if (k <= 44) begin
                           r.field_tag = TAG_NONCE;     r.field_offset = 12'(k - 13);
                        end else if (k <= 60) begin
                           r.field_tag = TAG_IV;        r.field_offset = 12'(k - 45);
                        end else if (k <= 68) begin
                           r.field_tag = TAG_RSC;       r.field_offset = 12'(k - 61);
                        end else if (k >= 77 && k <= 92) begin
                           r.field_tag = TAG_MIC;       r.field_offset = 12'(k - 77);
                           // zeroing only looks at the announced length, not the frame end
                           if (int'(eapol_len) + 4 >= 97) r.byte_out = 8'h00;
                        end else if (k >= 95 && (k - 95) < int'(key_data_len)) begin
                           r.field_tag = TAG_KEYDATA;   r.field_offset = 12'(k - 95);
                        end
                     end
                  end
               end
            end
         end
      end

      if (last) begin
         if (over) begin
            st = ST_OVERSIZE;
         end else begin
            len = p + 1;
            if (len < 36) begin
               st = ST_SHORT;
            end else if (rt_len < 16'd4 || int'(rt_len) >= len) begin
               st = ST_RADIOTAP;
            end else begin
               llc_end = int'(rt_len) + int'(hdr_len) + 8;
               hdr_end = llc_end + 4;
               if (llc_end > len)
                  st = ST_NO_LLC_ROOM;
               else if (first_err == ST_FOUR_ADDR || first_err == ST_LLC_BAD ||
                        first_err == ST_ETHERTYPE)
                  st = first_err;
               else if (hdr_end > len)
                  st = ST_EAPOL_TRUNC;
               else if (first_err == ST_NOT_KEY)
                  st = ST_NOT_KEY;
               else if (hdr_end + int'(eapol_len) > len)
                  st = ST_PAYLOAD_OVER;
               else if (len - hdr_end < 96)
                  st = ST_KEY_TRUNC;
               else if (hdr_end + 95 + int'(key_data_len) > len)
                  st = ST_KEYDATA_OVER;
               else
                  st = ST_OK;
            end
         end
         r.status = st;
         if (st == ST_OK || st == ST_KEYDATA_OVER) begin
            r.key_desc_type = desc_type;
            r.key_flags     = key_flags;
            r.key_size      = key_len;
            r.key_data_size = key_data_len;
            r.has_mic       = key_flags[8];
            r.from_ap       = ~fc[8];
         end
         clear_frame();
      end else begin
         pos = over ? POS_W'(MAX_FRAME_BYTES) : POS_W'(p + 1);
      end
   endtask

   always @(posedge clock) begin
      result_type predicted;
      result_type seen;
      if (reset) begin
         clear_frame();
         expected_bytes.delete();
         faults = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata, req_tlast, predicted);
            expected_bytes = {expected_bytes, predicted};
         end
         if (rsp_tvalid && rsp_tready) begin
            seen               = '0;
            seen.byte_out      = rsp_tdata[7:0];
            seen.in_payload    = rsp_tdata[8];
            seen.field_tag     = tag_type'(rsp_tdata[12:9]);
            seen.field_offset  = rsp_tdata[24:13];
            seen.frame_end     = rsp_tlast;
            seen.status        = status_type'(rsp_tdata[28:25]);
            seen.key_desc_type = rsp_tdata[36:29];
            seen.key_flags     = rsp_tdata[52:37];
            seen.key_size      = rsp_tdata[68:53];
            seen.key_data_size = rsp_tdata[84:69];
            seen.has_mic       = rsp_tdata[85];
            seen.from_ap       = rsp_tdata[86];
            if (expected_bytes.size() == 0) begin
               faults++;
               if (faults <= 10) $display("unexpected response: %s", show(seen));
            end else begin
               predicted = expected_bytes.pop_front();
               if (seen !== predicted || rsp_tdata[87] !== 1'b0) begin
                  faults++;
                  if (faults <= 10) begin
                     $display("response mismatch at %0t (pad bit %b)", $realtime, rsp_tdata[87]);
                     $display("  expected %s", show(predicted));
                     $display("  actual   %s", show(seen));
                  end
               end
            end
         end
      end
      fault_count   <= faults;
      pending_count <= expected_bytes.size();
   end

endmodule

// ===== tb/sv/eapol_key_frame_parser_tb.sv =====
// Testbench top for the EAPOL-Key frame parser: clock, reset, frame stimulus and verdict.
`timescale 1ns / 100ps

module eapol_key_frame_parser_tb;

   localparam int MAX_BYTES    = 4096;
   localparam int RANDOM_BYTES = 2000;   // stop drawing frames after this many bytes
   localparam int IDLE_LIMIT   = 2000;   // cycles with no transaction on either side

   // Ways a generated frame departs from a clean EAPOL-Key frame
   typedef enum int {
      FLAW_NONE,
      FLAW_TRUNC,         // cut at a random length
      FLAW_LLC,           // DSAP, SSAP or control byte wrong
      FLAW_ETHERTYPE,     // not 0x888E
      FLAW_NOT_KEY,       // EAPOL type other than key
      FLAW_FOUR_ADDR,     // to-DS and from-DS both set
      FLAW_BODY_LEN,      // random 16-bit EAPOL body length
      FLAW_KEYDATA_LEN,   // key data length beyond the frame
      FLAW_SHORT_BODY,    // body length too small for MIC zeroing
      FLAW_RADIOTAP,      // radiotap length below four or past the end
      FLAW_NOISE,         // random bytes only
      FLAW_OVERSIZE,      // well formed but longer than MAX_BYTES
      FLAW_COUNT
   } flaw_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] byte_in
   logic        req_tlast  = 1'b0; // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [7:0] byte_out, [8] in_payload, [12:9] field_tag, [24:13] field_offset,
   // [28:25] status, [36:29] key_desc_type, [52:37] key_flags, [68:53] key_size,
   // [84:69] key_data_size, [85] has_mic, [86] from_ap, [87] zero
   logic [87:0] rsp_tdata;
   logic        rsp_tlast;         // frame_end

   int fault_count;
   int pending_count;
   int idle_cycles = 0;

   logic [7:0] frame_bytes[$];
   int         sent_bytes = 0;
   logic       sender_calm = 1'b0;

   always #10 clock = ~clock;

   eapol_key_frame_parser #(.MAX_FRAME_BYTES(MAX_BYTES)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   ekfp_stream_checker #(.MAX_FRAME_BYTES(MAX_BYTES)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fault_count   (fault_count),
      .pending_count (pending_count)
   );

   // Watchdog: a correct run never goes this long without a transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response side: random stall before each transaction, with calm runs mixed in.
   initial begin
      int gap;
      int run_left;
      logic calm;
      run_left = 0;
      calm     = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (run_left == 0) begin
            run_left = $urandom_range(1, 80);
            calm     = ($urandom_range(0, 3) == 0);
         end
         run_left--;
         gap = calm ? 0 : $urandom_range(0, 15);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Appends one byte to the frame being built.
   task automatic add_byte(input logic [7:0] b);
      frame_bytes = {frame_bytes, b};
   endtask

   // One request transaction; valid stays high into the next byte when there is no gap.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= b;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic send_frame(input logic count_it);
      int j;
      sender_calm = ($urandom_range(0, 3) == 0);
      for (j = 0; j < frame_bytes.size(); j++) begin
         send_byte(frame_bytes[j], j == frame_bytes.size() - 1);
         if (count_it) sent_bytes++;
      end
   endtask

   // Builds one frame: radiotap, 802.11 header, LLC/SNAP, EAPOL header, key body, key data.
   task automatic build_frame(input flaw_type flaw);
      int          rt, kdl, n, j, cut;
      logic [15:0] fc, body, kdl_field;
      logic [7:0]  llc[8];
      frame_bytes.delete();
      if (flaw == FLAW_NOISE) begin
         n = $urandom_range(1, 60);
         repeat (n) add_byte(8'($urandom));
         return;
      end

      // radiotap: version/pad random, little-endian length, random fill
      rt = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 40) : $urandom_range(4, 12);
      if (flaw == FLAW_RADIOTAP)
         rt = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(200, 65535);
      add_byte(8'($urandom));
      add_byte(8'($urandom));
      add_byte(rt[7:0]);
      add_byte(rt[15:8]);
      for (j = 4; j < rt && rt <= 64; j++) add_byte(8'($urandom));

      // 802.11 header: frame control, duration, three addresses, sequence, options
      fc = 16'($urandom);
      fc[9:8] = (flaw == FLAW_FOUR_ADDR) ? 2'b11 : 2'($urandom_range(0, 2));
      add_byte(fc[7:0]);
      add_byte(fc[15:8]);
      repeat (22) add_byte(8'($urandom));
      if (fc[9:8] == 2'b11) repeat (6) add_byte(8'($urandom));
      if (fc[7]) repeat (2) add_byte(8'($urandom));

      // LLC/SNAP; the OUI bytes are not checked by the parser, so they are random
      llc[0] = 8'hAA; llc[1] = 8'hAA; llc[2] = 8'h03;
      llc[3] = 8'($urandom); llc[4] = 8'($urandom); llc[5] = 8'($urandom);
      llc[6] = 8'h88; llc[7] = 8'h8E;
      if (flaw == FLAW_LLC) begin
         j = $urandom_range(0, 2);
         llc[j] = llc[j] ^ 8'($urandom_range(1, 255));
      end
      if (flaw == FLAW_ETHERTYPE) begin
         j = $urandom_range(6, 7);
         llc[j] = llc[j] ^ 8'($urandom_range(1, 255));
      end
      for (j = 0; j < 8; j++) add_byte(llc[j]);

      // EAPOL header: version, type, big-endian body length
      kdl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
      if (flaw == FLAW_OVERSIZE) kdl = 4000;
      body = 16'(95 + kdl);
      if (flaw == FLAW_BODY_LEN)   body = 16'($urandom);
      if (flaw == FLAW_SHORT_BODY) body = 16'($urandom_range(0, 92));
      add_byte(8'($urandom));
      add_byte((flaw == FLAW_NOT_KEY) ? 8'h03 ^ 8'($urandom_range(1, 255)) : 8'h03);
      add_byte(body[15:8]);
      add_byte(body[7:0]);

      // key body, random apart from the key data length
      kdl_field = 16'(kdl);
      if (flaw == FLAW_KEYDATA_LEN) kdl_field = 16'($urandom_range(kdl + 1, 65535));
      for (j = 0; j < 95; j++) begin
         if (j == 93)      add_byte(kdl_field[15:8]);
         else if (j == 94) add_byte(kdl_field[7:0]);
         else              add_byte(8'($urandom));
      end
      repeat (kdl) add_byte(8'($urandom));

      // sometimes trailing bytes past the key data
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 4)) add_byte(8'($urandom));

      if (flaw == FLAW_TRUNC) begin
         cut = $urandom_range(1, frame_bytes.size());
         while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
   endtask

   initial begin
      int       f;
      flaw_type flaw;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: byte extremes and frames too short to parse, including a
      // radiotap length of zero.
      frame_bytes = '{8'h00};
      send_frame(1'b0);
      frame_bytes = '{8'hFF};
      send_frame(1'b0);
      frame_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h00};
      send_frame(1'b0);
      frame_bytes = '{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA,
                      8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55};
      send_frame(1'b0);

      // Random frames: the first ones take every flaw once (oversize included),
      // after that half are clean frames and half carry a random flaw.
      f = 0;
      while (sent_bytes < RANDOM_BYTES || f < int'(FLAW_COUNT)) begin
         if (f < int'(FLAW_COUNT))
            flaw = flaw_type'(f);
         else if ($urandom_range(0, 1) == 0)
            flaw = FLAW_NONE;
         else
            flaw = flaw_type'($urandom_range(int'(FLAW_TRUNC), int'(FLAW_NOISE)));
         build_frame(flaw);
         send_frame(flaw != FLAW_OVERSIZE);
         f++;
      end
      req_tvalid <= 1'b0;

      // Drain: the checker's pending count is registered, so it lags the last transaction.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fault_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== eapol_key_frame_parser.f =====
sv/ekfp_pkg.sv
sv/ekfp_step.sv
sv/eapol_key_frame_parser.sv
tb/sv/ekfp_stream_checker.sv
tb/sv/eapol_key_frame_parser_tb.sv
